[hdl/qcb_pkg.sv]
// Package for the bounded quadrature counter.
// Holds register indexes, the normalizer state type and the 4x decode table.
// No dependencies.
`default_nettype none

package qcb_pkg;

  localparam int unsigned CntW  = 32;
  localparam int unsigned StepW = 3;
  localparam int unsigned IdxW  = 2;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegMinPos = 2'd0;
  localparam logic [IdxW-1:0] RegMaxPos = 2'd1;
  localparam logic [IdxW-1:0] RegWrapEn = 2'd2;

  // normalizer: rem = (count - min) mod size, one quotient bit per cycle
  localparam int unsigned DivBits = CntW + 1;
  localparam int unsigned DivCntW = $clog2(DivBits + 1);

  typedef enum logic [1:0] {
    NORM_IDLE,
    NORM_DIVIDE,
    NORM_FINISH
  } norm_state_e;

  // index: bit3 new A, bit2 new B, bit1 previous A, bit0 previous B
  function automatic logic [StepW-1:0] decode_step(input logic [3:0] idx);
    logic [StepW-1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = 3'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = -3'sd1;
      4'd3, 4'd12:              s = 3'sd2;
      4'd6, 4'd9:               s = -3'sd2;
      default:                  s = 3'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/quadrature_counter_bounded.sv]
// Bounded 4x quadrature counter: decode, step, clamp or wrap, output skid stage.
// Depends on qcb_pkg (decode table, register indexes, normalizer state type).
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o | a_level_i, b_level_i
//  out     | source    | out_valid_o/ out_stall_i| position_o[31:0], step_taken_o
//  cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One sample per cycle while the input is not stalled: decode, step and
// bound happen in one pass from the count register into the result
// register. A two-entry output (result register plus skid) keeps the input
// open while one result waits. The input stalls for the cycle after every
// configuration write. A write that leaves wrap on and a sane range then runs
// a remainder pass (one quotient bit per cycle) that folds the raw count into
// the range as a side copy; the raw count itself is kept for clamp mode.
// Reset: count 0, previous levels 0, range full 32-bit signed, clamp mode.
`default_nettype none

module quadrature_counter_bounded
  import qcb_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [IdxW-1:0]        cfg_idx_i,
  input  wire logic [CntW-1:0]        cfg_data_i,
  // sample input
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   a_level_i,
  input  wire logic                   b_level_i,
  // result output
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [CntW-1:0]      position_o,
  output logic signed [StepW-1:0]     step_taken_o
);

  // ---------------- configuration registers ----------------
  logic signed [CntW-1:0] min_q, max_q;
  logic                   wrap_q;
  logic                   cfg_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= {1'b1, {(CntW-1){1'b0}}};
      max_q      <= {1'b0, {(CntW-1){1'b1}}};
      wrap_q     <= 1'b0;
      cfg_pend_q <= 1'b0;
    end else begin
      cfg_pend_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMinPos: min_q  <= cfg_data_i;
          RegMaxPos: max_q  <= cfg_data_i;
          RegWrapEn: wrap_q <= cfg_data_i[0];
          default: ;  // unmapped index, ignored
        endcase
      end
    end
  end

  // range derived values
  logic        [CntW+1:0] size_w;     // max - min + 1, up to 2^32
  logic                   inverted_w;
  logic                   size_one_w;

  assign size_w     = {{2{max_q[CntW-1]}}, max_q} - {{2{min_q[CntW-1]}}, min_q}
                      + {{(CntW+1){1'b0}}, 1'b1};
  assign inverted_w = min_q > max_q;
  assign size_one_w = (min_q == max_q);

  // ---------------- state ----------------
  logic [1:0]             prev_q;     // bit0 A, bit1 B
  logic signed [CntW-1:0] cnt_q;      // raw count
  logic signed [CntW-1:0] ncnt_q;     // raw count folded into the wrap range
  logic                   fold_q;     // ncnt_q is the base for the next wrap step

  // ---------------- handshakes ----------------
  logic out_valid_q, skid_valid_q;
  logic in_fire_w, out_fire_w;
  logic norm_busy_w;

  assign in_stall_o = skid_valid_q | norm_busy_w | cfg_pend_q;
  assign in_fire_w  = in_valid_i & ~in_stall_o;
  assign out_fire_w = out_valid_q & ~out_stall_i;

  // ---------------- decode and bound ----------------
  logic [3:0]             idx_w;
  logic signed [StepW-1:0] step_w;
  logic signed [CntW-1:0] base_w;
  logic signed [CntW:0]   sum_w;
  logic signed [CntW:0]   min_x, max_x;
  logic        [CntW+1:0] sum_dn_w, sum_up_w;
  logic signed [CntW-1:0] bound_w;

  assign idx_w    = {a_level_i, b_level_i, prev_q[0], prev_q[1]};
  assign step_w   = decode_step(idx_w);
  assign base_w   = (wrap_q && fold_q) ? ncnt_q : cnt_q;
  assign sum_w    = {base_w[CntW-1], base_w} + {{(CntW+1-StepW){step_w[StepW-1]}}, step_w};
  assign min_x    = {min_q[CntW-1], min_q};
  assign max_x    = {max_q[CntW-1], max_q};
  assign sum_dn_w = {sum_w[CntW], sum_w} - size_w;
  assign sum_up_w = {sum_w[CntW], sum_w} + size_w;

  // In wrap mode the base (stored count, or its folded copy after a range
  // write) is inside the range, so one correction by the range size is
  // enough unless the range is one value.
  always_comb begin
    if (inverted_w) begin
      bound_w = max_q;
    end else if (wrap_q) begin
      if (size_one_w)         bound_w = min_q;
      else if (sum_w > max_x) bound_w = sum_dn_w[CntW-1:0];
      else if (sum_w < min_x) bound_w = sum_up_w[CntW-1:0];
      else                    bound_w = sum_w[CntW-1:0];
    end else begin
      if (sum_w < min_x)      bound_w = min_q;
      else if (sum_w > max_x) bound_w = max_q;
      else                    bound_w = sum_w[CntW-1:0];
    end
  end

  // ---------------- range normalizer ----------------
  norm_state_e            nst_q, nst_d;
  logic                   norm_start_w, norm_load_w, norm_shift_w, norm_done_w;
  logic        [CntW+1:0] diff_w;
  logic        [DivBits-1:0] mag_q, rem_q;
  logic                   neg_q;
  logic        [DivCntW-1:0] dcnt_q;
  logic        [DivBits:0] rem_sh_w, rem_sub_w;
  logic        [CntW+1:0] rfix_w;
  logic signed [CntW-1:0] norm_cnt_w;

  assign norm_start_w = cfg_pend_q & ~cfg_we_i & wrap_q & ~inverted_w;

  always_comb begin
    nst_d = nst_q;
    if (cfg_we_i) begin
      nst_d = NORM_IDLE;
    end else begin
      case (nst_q)
        NORM_IDLE:   if (norm_start_w) nst_d = NORM_DIVIDE;
        NORM_DIVIDE: if (dcnt_q == DivCntW'(1)) nst_d = NORM_FINISH;
        NORM_FINISH: nst_d = NORM_IDLE;
        default:     nst_d = NORM_IDLE;
      endcase
    end
  end

  always_comb begin
    norm_busy_w  = 1'b0;
    norm_load_w  = 1'b0;
    norm_shift_w = 1'b0;
    norm_done_w  = 1'b0;
    case (nst_q)
      NORM_IDLE:   norm_load_w = norm_start_w;
      NORM_DIVIDE: begin
        norm_busy_w  = 1'b1;
        norm_shift_w = ~cfg_we_i;
      end
      NORM_FINISH: begin
        norm_busy_w = 1'b1;
        norm_done_w = ~cfg_we_i;
      end
      default: ;
    endcase
  end

  assign diff_w    = {{2{cnt_q[CntW-1]}}, cnt_q} - {{2{min_q[CntW-1]}}, min_q};
  assign rem_sh_w  = {rem_q, mag_q[DivBits-1]};
  assign rem_sub_w = rem_sh_w - size_w[DivBits:0];
  assign rfix_w    = (neg_q && (rem_q != '0)) ? size_w - {1'b0, rem_q} : {1'b0, rem_q};
  assign norm_cnt_w = min_q + rfix_w[CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nst_q  <= NORM_IDLE;
      dcnt_q <= '0;
    end else begin
      nst_q <= nst_d;
      if (norm_load_w)       dcnt_q <= DivCntW'(DivBits);
      else if (norm_shift_w) dcnt_q <= dcnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (norm_load_w) begin
      neg_q <= diff_w[CntW+1];
      mag_q <= diff_w[CntW+1] ? DivBits'(-diff_w) : diff_w[DivBits-1:0];
      rem_q <= '0;
    end else if (norm_shift_w) begin
      mag_q <= {mag_q[DivBits-2:0], 1'b0};
      rem_q <= (rem_sh_w >= {1'b0, size_w[DivBits-1:0]}) ?
               rem_sub_w[DivBits-1:0] : rem_sh_w[DivBits-1:0];
    end
    if (norm_done_w) ncnt_q <= norm_cnt_w;
  end

  // folded copy is valid from the end of the pass to the next sample or write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b0;
    end else if (cfg_we_i || in_fire_w) begin
      fold_q <= 1'b0;
    end else if (norm_done_w) begin
      fold_q <= 1'b1;
    end
  end

  // ---------------- count and previous levels ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= '0;
    end else if (in_fire_w) begin
      cnt_q  <= bound_w;
      prev_q <= {b_level_i, a_level_i};
    end
  end

  // ---------------- result register and skid ----------------
  logic signed [CntW-1:0]  pos_q, skid_pos_q;
  logic signed [StepW-1:0] stp_q, skid_stp_q;
  logic                    to_out_w, to_skid_w;

  assign to_out_w  = in_fire_w & (~out_valid_q | out_fire_w);
  assign to_skid_w = in_fire_w & out_valid_q & ~out_fire_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (to_skid_w)                       skid_valid_q <= 1'b1;
      else if (out_fire_w)                 skid_valid_q <= 1'b0;
      if (to_out_w || (out_fire_w && skid_valid_q)) out_valid_q <= 1'b1;
      else if (out_fire_w)                 out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (to_out_w) begin
      pos_q <= bound_w;
      stp_q <= step_w;
    end else if (out_fire_w && skid_valid_q) begin
      pos_q <= skid_pos_q;
      stp_q <= skid_stp_q;
    end
    if (to_skid_w) begin
      skid_pos_q <= bound_w;
      skid_stp_q <= step_w;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign position_o   = pos_q;
  assign step_taken_o = stp_q;

  // ---------------- assertions ----------------
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the result register is empty");

  a_no_accept_while_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nst_q != NORM_IDLE) |-> !in_fire_w)
    else $error("sample taken during range normalization");

  a_norm_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (norm_done_w && !cfg_we_i) |=> (ncnt_q >= min_q && ncnt_q <= max_q))
    else $error("normalized count outside range");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire_w && skid_valid_q) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry lost on transfer");

endmodule

`default_nettype wire
